[src/call_return_trace_monitor_unit_macros.svh]
// Assertion helpers for the call/return trace monitor.
// Every check is sampled on the rising edge of aclk and is
// switched off while aresetn is low.
`ifndef CALL_RETURN_TRACE_MONITOR_UNIT_MACROS_SVH
`define CALL_RETURN_TRACE_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define CRTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define CRTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/crtm_pkg.sv]
package crtm_pkg;

    localparam int DEPTH_BITS_DEFAULT = 16;
    localparam int CMD_QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS          = 1;

    localparam logic [6:0]  OPC_MASK   = 7'h7f;
    localparam logic [6:0]  OPC_JAL    = 7'h6f;
    localparam logic [6:0]  OPC_JALR   = 7'h67;
    localparam logic [2:0]  F3_JALR    = 3'd0;
    localparam logic [4:0]  REG_ZERO   = 5'd0;
    localparam logic [4:0]  REG_RA     = 5'd1;
    localparam logic [31:0] UPPER_ONES = 32'hfffff000;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_CALL   = 2'd1,
        KIND_RETURN = 2'd2
    } jump_kind_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc;
        logic [31:0] rs1_value;
    } crtm_in_t;

    typedef struct packed {
        logic [1:0]  jump_kind;
        logic [31:0] target;
        logic [15:0] depth;
        logic        underflow;
    } crtm_out_t;

    // Classified instruction, passed from front end to back end.
    typedef struct packed {
        jump_kind_t  kind;
        logic [31:0] target;
    } crtm_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } crtm_qstat_t;

endpackage

[src/crtm_front.sv]
module crtm_front (
    input  crtm_pkg::crtm_in_t  in_data,
    output crtm_pkg::crtm_cmd_t cmd
);

    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic        is_jal;
    logic        is_jalr_op;
    logic        is_jalr;
    logic [31:0] jal_imm;
    logic [31:0] jalr_imm;
    logic [31:0] jalr_sum;

    assign w          = in_data.instruction;
    assign opc        = w[6:0] & crtm_pkg::OPC_MASK;
    assign f3         = w[14:12];
    assign rd         = w[11:7];
    assign rs1        = w[19:15];
    assign is_jal     = (opc == crtm_pkg::OPC_JAL);
    assign is_jalr_op = (opc == crtm_pkg::OPC_JALR);
    assign is_jalr    = is_jalr_op && (f3 == crtm_pkg::F3_JALR);

    // J-type immediate, sign bit is bit 20 of the offset
    assign jal_imm  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign jalr_imm = {20'(crtm_pkg::UPPER_ONES[31:12] & {20{w[31]}}), w[31:20]};
    assign jalr_sum = in_data.rs1_value + jalr_imm;

    always_comb begin
        cmd.kind = crtm_pkg::KIND_OTHER;
        if ((is_jal || is_jalr) && rd == crtm_pkg::REG_RA) begin
            cmd.kind = crtm_pkg::KIND_CALL;
        end else if (is_jalr && rd == crtm_pkg::REG_ZERO && rs1 == crtm_pkg::REG_RA) begin
            cmd.kind = crtm_pkg::KIND_RETURN;
        end

        if (is_jal) begin
            cmd.target = in_data.pc + jal_imm;
        end else if (is_jalr_op) begin
            cmd.target = {jalr_sum[31:1], 1'b0};
        end else begin
            cmd.target = 32'd0;
        end
    end

endmodule

[src/crtm_queue.sv]
module crtm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  crtm_pkg::crtm_cmd_t   push_data,
    input  logic                  pop,
    output crtm_pkg::crtm_cmd_t   pop_data,
    output crtm_pkg::crtm_qstat_t stat
);

    localparam int CNT_BITS = crtm_pkg::QPTR_BITS + 1;

    crtm_pkg::crtm_cmd_t          entry_reg [crtm_pkg::CMD_QUEUE_DEPTH];
    logic [crtm_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [crtm_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]            count_reg, count_next;

    assign stat.full  = (count_reg == CNT_BITS'(crtm_pkg::CMD_QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/crtm_back.sv]
module crtm_back #(
    parameter int DEPTH_BITS = crtm_pkg::DEPTH_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  crtm_pkg::crtm_cmd_t   cmd,
    input  crtm_pkg::crtm_qstat_t qstat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crtm_pkg::crtm_out_t   m_data
);

    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic [DEPTH_BITS-1:0] shown;
    logic                  under;
    logic                  valid_reg, valid_next;
    crtm_pkg::crtm_out_t   data_reg, data_next;

    // Take the next command whenever the output register is free or draining.
    assign pop = !qstat.empty && (!valid_reg || m_ready);

    always_comb begin
        depth_next = depth_reg;
        shown      = depth_reg;
        under      = 1'b0;
        case (cmd.kind)
            crtm_pkg::KIND_CALL: begin
                if (depth_reg != '1) begin
                    depth_next = depth_reg + 1'b1;
                end
                shown = depth_next;
            end
            crtm_pkg::KIND_RETURN: begin
                if (depth_reg != '0) begin
                    depth_next = depth_reg - 1'b1;
                end else begin
                    under = 1'b1;
                end
            end
            default: begin
            end
        endcase

        data_next.jump_kind = cmd.kind;
        data_next.target    = cmd.target;
        data_next.depth     = 16'(shown);
        data_next.underflow = under;

        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                depth_reg <= depth_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

[src/call_return_trace_monitor_unit.sv]
// Flow: a transaction accepted at a clock edge is decoded and written into the queue at that edge;
//   the back end then pops it, updates the depth and registers the result into the output register.
// Throughput: one instruction per cycle unless m_ready stalls the output; the back end drains one queue entry a cycle.
// Reset (aresetn low, synchronous): nesting depth to zero, queue emptied, m_valid low.
// s_ready is high in the first cycle after reset; no clearing pass is needed.
`include "call_return_trace_monitor_unit_macros.svh"

module call_return_trace_monitor_unit #(
    parameter int DEPTH_BITS = crtm_pkg::DEPTH_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crtm_pkg::crtm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output crtm_pkg::crtm_out_t m_data
);

    // Front end: decode the instruction word and compute the jump target.
    // This is purely combinational; the queue entry is the pipeline register.
    crtm_pkg::crtm_cmd_t   front_cmd;
    crtm_pkg::crtm_cmd_t   queue_cmd;
    crtm_pkg::crtm_qstat_t q_stat;
    logic                  cmd_push;
    logic                  cmd_pop;

    crtm_front u_front (
        .in_data (s_data),
        .cmd     (front_cmd)
    );

    // Accept whenever the queue has a free slot. With two entries and a
    // back end that pops every cycle the output is free, the front end never
    // waits on a result that is still being taken downstream.
    assign s_ready  = !q_stat.full;
    assign cmd_push = s_valid && s_ready;

    crtm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (front_cmd),
        .pop       (cmd_pop),
        .pop_data  (queue_cmd),
        .stat      (q_stat)
    );

    // Back end: own the nesting-depth counter, saturate on calls, flag
    // underflow on returns at depth zero, and hold the result until taken.
    crtm_back #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (queue_cmd),
        .qstat   (q_stat),
        .pop     (cmd_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Underflow can only be reported on a return seen at depth zero.
    `CRTM_ASSERT_IMP(a_underflow_is_return, m_valid && m_data.underflow, m_data.jump_kind == crtm_pkg::KIND_RETURN && m_data.depth == 16'd0, "underflow on a non-return or nonzero depth")
    // Never pop an empty queue.
    `CRTM_ASSERT_IMP(a_no_pop_empty, cmd_pop, !q_stat.empty, "back end popped an empty queue")
    // A full queue and an empty queue are exclusive.
    `CRTM_ASSERT_IMP(a_qstat_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue reports full and empty")
    // A pop always produces a valid result on the next edge.
    `CRTM_ASSERT_NEXT(a_pop_gives_result, cmd_pop, m_valid, "popped command did not reach the output")

endmodule

[sim/tb_call_return_trace_monitor_unit.sv]
module tb_call_return_trace_monitor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Match the counter width of the instance so saturation lands where the block saturates.
    localparam int DEPTH_BITS   = crtm_pkg::DEPTH_BITS_DEFAULT;
    localparam int RANDOM_ITEMS = 1200;
    localparam int NEST_LEVELS  = 100;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    crtm_pkg::crtm_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    crtm_pkg::crtm_out_t m_data;

    // Shadow of the nesting-depth counter, advanced once per accepted transaction.
    logic [DEPTH_BITS-1:0] depth_track = '0;
    // Results still owed by the block, oldest first.
    crtm_pkg::crtm_out_t   trace_expect_q[$];
    int                    mismatch_cnt = 0;

    // Sender burst/gap state and idling switches for both sides.
    int                    burst_left   = 0;
    bit                    tx_gap_en    = 1'b1;
    bit                    rx_stall_en  = 1'b1;
    int                    rx_left      = 0;

    call_return_trace_monitor_unit #(
        .DEPTH_BITS(DEPTH_BITS)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Classify one retired instruction, compute its jump target and move the depth shadow.
    function automatic crtm_pkg::crtm_out_t predict_trace(input crtm_pkg::crtm_in_t item);
        logic [31:0]         w;
        logic [6:0]          opc;
        logic [2:0]          f3;
        logic [4:0]          rd;
        logic [4:0]          rs1;
        logic                is_jalr;
        logic                is_call;
        logic                is_ret;
        logic [31:0]         imm;
        logic [31:0]         shown;
        crtm_pkg::crtm_out_t res;
        w       = item.instruction;
        opc     = w[6:0] & crtm_pkg::OPC_MASK;
        f3      = w[14:12];
        rd      = w[11:7];
        rs1     = w[19:15];
        is_jalr = (opc == crtm_pkg::OPC_JALR) && (f3 == crtm_pkg::F3_JALR);
        is_call = ((opc == crtm_pkg::OPC_JAL) || is_jalr) && (rd == crtm_pkg::REG_RA);
        is_ret  = is_jalr && (rd == crtm_pkg::REG_ZERO) && (rs1 == crtm_pkg::REG_RA);
        res     = '0;

        // Target comes from the opcode alone: a JALR with a stray funct3 still carries one.
        if (opc == crtm_pkg::OPC_JAL) begin
            imm        = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            res.target = item.pc + imm;
        end else if (opc == crtm_pkg::OPC_JALR) begin
            imm        = {{20{w[31]}}, w[31:20]};
            res.target = (item.rs1_value + imm) & ~32'd1;
        end

        // Calls report the depth after the increment, returns the depth before the decrement.
        if (is_call) begin
            res.jump_kind = crtm_pkg::KIND_CALL;
            if (depth_track != '1) begin
                depth_track = depth_track + 1'b1;
            end
            shown = 32'(depth_track);
        end else if (is_ret) begin
            res.jump_kind = crtm_pkg::KIND_RETURN;
            shown         = 32'(depth_track);
            if (depth_track != '0) begin
                depth_track = depth_track - 1'b1;
            end else begin
                res.underflow = 1'b1;
            end
        end else begin
            res.jump_kind = crtm_pkg::KIND_OTHER;
            shown         = 32'(depth_track);
        end
        res.depth = shown[15:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------

    function automatic logic [31:0] jal_word(input logic [4:0] rd, input logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, crtm_pkg::OPC_JAL};
    endfunction

    function automatic logic [31:0] jalr_word(input logic [4:0] rd, input logic [4:0] rs1,
                                              input logic [2:0] f3, input logic [11:0] imm);
        return {imm, rs1, f3, rd, crtm_pkg::OPC_JALR};
    endfunction

    // Random call: JAL or JALR (funct3 zero) with rd = ra, everything else random.
    function automatic logic [31:0] rand_call_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            w[6:0] = crtm_pkg::OPC_JAL;
        end else begin
            w[6:0]   = crtm_pkg::OPC_JALR;
            w[14:12] = crtm_pkg::F3_JALR;
        end
        w[11:7] = crtm_pkg::REG_RA;
        return w;
    endfunction

    // Random return: JALR x0, offset(ra); the offset is usually zero as compilers emit it.
    function automatic logic [31:0] rand_return_word();
        logic [31:0] w;
        w        = $urandom;
        w[6:0]   = crtm_pkg::OPC_JALR;
        w[14:12] = crtm_pkg::F3_JALR;
        w[11:7]  = crtm_pkg::REG_ZERO;
        w[19:15] = crtm_pkg::REG_RA;
        if ($urandom_range(0, 3) != 0) begin
            w[31:20] = '0;
        end
        return w;
    endfunction

    // Jump opcode with register and funct3 fields that often just miss a call or return.
    function automatic logic [31:0] rand_near_miss_word();
        logic [31:0] w;
        w      = $urandom;
        w[6:0] = ($urandom_range(0, 1) == 0) ? crtm_pkg::OPC_JAL : crtm_pkg::OPC_JALR;
        case ($urandom_range(0, 2))
            0: w[11:7] = crtm_pkg::REG_ZERO;
            1: w[11:7] = crtm_pkg::REG_RA;
            default: ;
        endcase
        if ($urandom_range(0, 1) == 0) begin
            w[19:15] = crtm_pkg::REG_RA;
        end
        if ($urandom_range(0, 1) == 0) begin
            w[14:12] = crtm_pkg::F3_JALR;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one transaction per call, with burst/gap idling
    // ------------------------------------------------------------------

    // Called just after a rising edge; returns at the edge that accepts the transaction.
    task automatic send_trace(input logic [31:0] instr, input logic [31:0] pc,
                              input logic [31:0] rs1v);
        crtm_pkg::crtm_in_t item;
        int                 gap;
        item.instruction = instr;
        item.pc          = pc;
        item.rs1_value   = rs1v;

        // Start a new burst, dropping valid for a random gap first.
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = tx_gap_en ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end

        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);

        burst_left--;
        trace_expect_q.push_back(predict_trace(item));
    endtask

    // ------------------------------------------------------------------
    // Receiver: alternate ready runs and stalls, sometimes a long ready run
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_left <= 0;
        end else if (!rx_stall_en) begin
            m_ready <= 1'b1;
        end else if (rx_left == 0) begin
            if (m_ready) begin
                m_ready <= 1'b0;
                rx_left <= $urandom_range(0, 4);
            end else begin
                m_ready <= 1'b1;
                rx_left <= ($urandom_range(0, 7) == 0) ? 47 : $urandom_range(0, 11);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_cnt++;
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        crtm_pkg::crtm_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (trace_expect_q.size() == 0) begin
                mismatch_cnt++;
                $error("unexpected result transaction: 0x%0h", m_data);
            end else begin
                exp_r = trace_expect_q.pop_front();
                compare_field("jump_kind", 32'(exp_r.jump_kind), 32'(m_data.jump_kind));
                compare_field("target",    exp_r.target,         m_data.target);
                compare_field("depth",     32'(exp_r.depth),     32'(m_data.depth));
                compare_field("underflow", 32'(exp_r.underflow), 32'(m_data.underflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every jump class, offset extremes, near misses and returns past depth zero.
    task automatic test_directed_jumps();
        // Calls through JAL: zero offset, largest forward offset across the top of memory,
        // most negative offset from address zero.
        send_trace(jal_word(crtm_pkg::REG_RA, 21'h000000), 32'h0000_1000, 32'h0);
        send_trace(jal_word(crtm_pkg::REG_RA, 21'h0ffffe), 32'hffff_fff0, 32'hffff_ffff);
        send_trace(jal_word(crtm_pkg::REG_RA, 21'h100000), 32'h0000_0000, 32'h0);
        // Plain JAL without a link: other, but target still reported.
        send_trace(jal_word(crtm_pkg::REG_ZERO, 21'h1ffffe), 32'h8000_0000, 32'h0);
        // Calls through JALR with an odd base and an odd offset.
        send_trace(jalr_word(crtm_pkg::REG_RA, 5'd5, crtm_pkg::F3_JALR, 12'h7ff),
                   32'h0, 32'h0000_1001);
        // JALR ra, 0(ra) links, so it counts as a call rather than a return.
        send_trace(jalr_word(crtm_pkg::REG_RA, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h000),
                   32'h4, 32'hffff_ffff);
        // JALR opcode with a nonzero funct3: other, JALR-style target.
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, 3'd1, 12'h000),
                   32'h8, 32'h0000_2000);
        send_trace(jalr_word(crtm_pkg::REG_RA, crtm_pkg::REG_RA, 3'd7, 12'hfff),
                   32'hc, 32'h0000_0000);
        // Wrong rd or wrong rs1 for a return.
        send_trace(jalr_word(5'd5, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h000),
                   32'h10, 32'h1234_5678);
        send_trace(jalr_word(crtm_pkg::REG_ZERO, 5'd2, crtm_pkg::F3_JALR, 12'h000),
                   32'h14, 32'h8765_4321);
        // Non-jump words, including all zeros, all ones and an opcode next to JAL.
        send_trace(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_trace(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_trace(32'h0000_006e, 32'h5555_5555, 32'haaaa_aaaa);
        // Unwind all five calls, then two returns at depth zero to raise underflow.
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h000),
                   32'h18, 32'h0000_3000);
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h800),
                   32'h1c, 32'h0000_0000);
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h004),
                   32'h20, 32'hffff_fffd);
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h000),
                   32'h24, 32'h0000_0100);
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h000),
                   32'h28, 32'h0000_0200);
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'h000),
                   32'h2c, 32'h0000_0300);
        send_trace(jalr_word(crtm_pkg::REG_ZERO, crtm_pkg::REG_RA, crtm_pkg::F3_JALR, 12'hfff),
                   32'h30, 32'h0000_0001);
    endtask

    // Balanced call/return walk near depth zero, mixed with near misses and random words.
    task automatic test_random_traffic();
        logic [31:0] w;
        int          pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                w = rand_call_word();
            end else if (pick < 60) begin
                w = rand_return_word();
            end else if (pick < 78) begin
                w = rand_near_miss_word();
            end else begin
                w = $urandom;
            end
            // Hold the sender and receiver at full rate for a stretch now and then.
            if (n % 200 == 100) begin
                tx_gap_en   = 1'b0;
                rx_stall_en = 1'b0;
            end else if (n % 200 == 150) begin
                tx_gap_en   = 1'b1;
                rx_stall_en = 1'b1;
            end
            send_trace(w, $urandom, $urandom);
        end
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Climb well above the random walk, unwind to zero, then return past the bottom.
    task automatic test_deep_nesting();
        // Run the climb at full rate; idle again for the unwind.
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        repeat (NEST_LEVELS) send_trace(rand_call_word(), $urandom, $urandom);
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        while (depth_track != '0) begin
            send_trace(rand_return_word(), $urandom, $urandom);
        end
        repeat (3) send_trace(rand_return_word(), $urandom, $urandom);
        send_trace(rand_call_word(), $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_jumps();
        test_random_traffic();
        test_deep_nesting();

        // Drop valid and drain until every expected result has been taken.
        s_valid <= 1'b0;
        while (trace_expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest correct run.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/crtm_pkg.sv
src/crtm_front.sv
src/crtm_queue.sv
src/crtm_back.sv
src/call_return_trace_monitor_unit.sv
sim/tb_call_return_trace_monitor_unit.sv
